FILE: src/led_blink_pattern_sequencer_defines.svh
// assertion macros for the led blink pattern sequencer
// no dependencies; included by the files that carry assertions
`ifndef LED_BLINK_PATTERN_SEQUENCER_DEFINES_SVH
`define LED_BLINK_PATTERN_SEQUENCER_DEFINES_SVH

`ifndef ASSERT_OFF
`define LBPS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lbps assertion failed");
`define LBPS_ASSERT_MSG(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);
`else
`define LBPS_ASSERT(lbl, clk, rst, prop)
`define LBPS_ASSERT_MSG(lbl, clk, rst, prop, msg)
`endif

`endif

FILE: src/lbps_pkg.sv
// types and codes for the led blink pattern sequencer
// no dependencies
package lbps_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_SOLID = 2'd1;
  localparam logic [1:0] OP_BLINK = 2'd2;

  localparam logic [1:0] MODE_ON   = 2'd0;
  localparam logic [1:0] MODE_OFF  = 2'd1;
  localparam logic [1:0] MODE_ONCE = 2'd2;
  localparam logic [1:0] MODE_CONT = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic        level;
    logic [15:0] on_time;
    logic [15:0] off_time;
    logic [7:0]  burst_length;
    logic [15:0] repeat_gap;
  } lbps_in_t;

  typedef struct packed {
    logic       led;
    logic       error;
    logic [1:0] mode_now;
  } lbps_out_t;

endpackage

FILE: src/led_blink_pattern_sequencer.sv
// led blink pattern sequencer: commands and ms ticks in, led level and mode out
// depends on lbps_pkg and led_blink_pattern_sequencer_defines.svh
//
//   channel | signals                         | carries
//   in      | in_valid, in_ready, in_data     | tick, solid or blink command
//   out     | out_valid, out_ready, out_data  | led, error, mode after the item
//
// one item per cycle sustained while results are taken
// the item sits in an input register, the led/timer update runs combinationally
// into the state and the result register
// reset: solid off, led off, timer stopped, all timings zero
// a stalled result holds the result register; the input register still takes
// an item, further items wait until the result is taken
`include "led_blink_pattern_sequencer_defines.svh"

module led_blink_pattern_sequencer
  import lbps_pkg::*;
#(
  parameter int TIME_BITS  = 16,
  parameter int COUNT_BITS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  lbps_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output lbps_out_t out_data
);

  // input register
  logic     in_full;
  lbps_in_t in_q;
  logic     advance;

  // sequencer state
  logic [1:0]            mode_reg, mode_next;
  logic                  led_reg, led_next;
  logic                  timer_active, timer_active_next;
  logic [TIME_BITS-1:0]  ticks_left, ticks_left_next;
  logic [COUNT_BITS-1:0] pulses_left, pulses_left_next;
  logic [TIME_BITS-1:0]  cur_on, cur_on_next;
  logic [TIME_BITS-1:0]  cur_off, cur_off_next;
  logic [COUNT_BITS-1:0] cur_burst, cur_burst_next;
  logic [TIME_BITS-1:0]  cur_gap, cur_gap_next;
  logic [1:0]            saved_mode, saved_mode_next;
  logic [TIME_BITS-1:0]  saved_on, saved_on_next;
  logic [TIME_BITS-1:0]  saved_off, saved_off_next;
  logic [COUNT_BITS-1:0] saved_burst, saved_burst_next;
  logic [TIME_BITS-1:0]  saved_gap, saved_gap_next;
  logic                  err_next;

  // command fields narrowed to the stored widths
  logic [TIME_BITS-1:0]  on_t, off_t, gap_t;
  logic [COUNT_BITS-1:0] burst_t;
  logic [COUNT_BITS-1:0] pulses_dec;

  assign on_t    = TIME_BITS'(in_q.on_time);
  assign off_t   = TIME_BITS'(in_q.off_time);
  assign gap_t   = TIME_BITS'(in_q.repeat_gap);
  assign burst_t = COUNT_BITS'(in_q.burst_length);

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  assign pulses_dec = (pulses_left != '0) ? pulses_left - COUNT_BITS'(1) : pulses_left;

  always_comb begin
    mode_next         = mode_reg;
    led_next          = led_reg;
    timer_active_next = timer_active;
    ticks_left_next   = ticks_left;
    pulses_left_next  = pulses_left;
    cur_on_next       = cur_on;
    cur_off_next      = cur_off;
    cur_burst_next    = cur_burst;
    cur_gap_next      = cur_gap;
    saved_mode_next   = saved_mode;
    saved_on_next     = saved_on;
    saved_off_next    = saved_off;
    saved_burst_next  = saved_burst;
    saved_gap_next    = saved_gap;
    err_next          = 1'b0;

    unique case (in_q.operation)
      OP_TICK: begin
        if (timer_active) begin
          if (ticks_left <= TIME_BITS'(1)) begin
            ticks_left_next = '0;
            if (!led_reg) begin
              led_next        = 1'b1;
              ticks_left_next = cur_on;
            end else begin
              led_next         = 1'b0;
              pulses_left_next = pulses_dec;
              if (pulses_dec != '0 && cur_off != '0) begin
                ticks_left_next = cur_off;
              end else if (mode_reg == MODE_ONCE) begin
                // burst done: bring back the earlier mode and timings
                cur_on_next    = saved_on;
                cur_off_next   = saved_off;
                cur_burst_next = saved_burst;
                cur_gap_next   = saved_gap;
                mode_next      = saved_mode;
                if (!saved_mode[1]) begin
                  led_next          = (saved_mode == MODE_ON);
                  timer_active_next = 1'b0;
                end else begin
                  led_next          = 1'b1;
                  pulses_left_next  = saved_burst;
                  ticks_left_next   = saved_on;
                  timer_active_next = 1'b1;
                end
              end else if (mode_reg == MODE_CONT) begin
                pulses_left_next = cur_burst;
                ticks_left_next  = cur_gap;
              end else begin
                timer_active_next = 1'b0;
              end
            end
          end else begin
            ticks_left_next = ticks_left - TIME_BITS'(1);
          end
        end
      end
      OP_SOLID: begin
        mode_next         = in_q.level ? MODE_ON : MODE_OFF;
        led_next          = in_q.level;
        timer_active_next = 1'b0;
      end
      OP_BLINK: begin
        if (on_t == '0 || (off_t == '0 && burst_t != '0)) begin
          err_next = 1'b1;
        end else begin
          if (gap_t == '0) begin
            saved_mode_next  = mode_reg;
            saved_on_next    = cur_on;
            saved_off_next   = cur_off;
            saved_burst_next = cur_burst;
            saved_gap_next   = cur_gap;
          end
          cur_on_next       = on_t;
          cur_off_next      = off_t;
          cur_burst_next    = burst_t;
          cur_gap_next      = gap_t;
          mode_next         = (gap_t != '0) ? MODE_CONT : MODE_ONCE;
          led_next          = 1'b1;
          pulses_left_next  = burst_t;
          ticks_left_next   = on_t;
          timer_active_next = 1'b1;
        end
      end
      default: begin
        // unused operation code leaves the state alone
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.led      <= led_next;
      out_data.error    <= err_next;
      out_data.mode_now <= mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg     <= MODE_OFF;
      led_reg      <= 1'b0;
      timer_active <= 1'b0;
      ticks_left   <= '0;
      pulses_left  <= '0;
      cur_on       <= '0;
      cur_off      <= '0;
      cur_burst    <= '0;
      cur_gap      <= '0;
      saved_mode   <= MODE_OFF;
      saved_on     <= '0;
      saved_off    <= '0;
      saved_burst  <= '0;
      saved_gap    <= '0;
    end else if (advance) begin
      mode_reg     <= mode_next;
      led_reg      <= led_next;
      timer_active <= timer_active_next;
      ticks_left   <= ticks_left_next;
      pulses_left  <= pulses_left_next;
      cur_on       <= cur_on_next;
      cur_off      <= cur_off_next;
      cur_burst    <= cur_burst_next;
      cur_gap      <= cur_gap_next;
      saved_mode   <= saved_mode_next;
      saved_on     <= saved_on_next;
      saved_off    <= saved_off_next;
      saved_burst  <= saved_burst_next;
      saved_gap    <= saved_gap_next;
    end
  end

  // timer runs exactly in the blink modes
  `LBPS_ASSERT(a_timer_mode, clk, rst, timer_active == mode_reg[1])
  // solid modes drive the led to their own level
  `LBPS_ASSERT(a_solid_led, clk, rst, !mode_reg[1] |-> (led_reg == (mode_reg == MODE_ON)))
  // a result mirrors the state it left behind
  `LBPS_ASSERT_MSG(a_out_state, clk, rst, advance |=> (out_valid && out_data.led == led_reg && out_data.mode_now == mode_reg), "result does not match state")
  // a rejected blink leaves the mode untouched
  `LBPS_ASSERT_MSG(a_err_keep, clk, rst, (advance && err_next) |=> $stable(mode_reg), "rejected blink changed mode")

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for led_blink_pattern_sequencer: directed commands, long
// output stall and random tick/command traffic, checked against an in-bench led model
// depends on lbps_pkg and the led_blink_pattern_sequencer rtl
`timescale 1ns / 100ps

module tb_top
  import lbps_pkg::*;
();

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  lbps_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  lbps_out_t out_data;

  led_blink_pattern_sequencer u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // led model state
  logic [1:0]  led_mode;
  logic        led_lit;
  logic        timer_run;
  logic [15:0] ticks_rem;
  logic [7:0]  pulses_rem;
  logic [15:0] cur_on_t;
  logic [15:0] cur_off_t;
  logic [7:0]  cur_burst_n;
  logic [15:0] cur_gap_t;
  logic [1:0]  keep_mode;
  logic [15:0] keep_on_t;
  logic [15:0] keep_off_t;
  logic [7:0]  keep_burst_n;
  logic [15:0] keep_gap_t;

  lbps_out_t exp_status_q[$];
  lbps_out_t want_status;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_len;
  int n_sent;
  int n_checked;
  int n_rejected;
  int n_restores;
  int n_fail;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("timeout at %0t", $time);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void enter_mode(input logic [1:0] m);
    led_mode = m;
    if (m == MODE_ON || m == MODE_OFF) begin
      led_lit   = (m == MODE_ON);
      timer_run = 1'b0;
    end else begin
      led_lit    = 1'b1;
      pulses_rem = cur_burst_n;
      ticks_rem  = cur_on_t;
      timer_run  = 1'b1;
    end
  endfunction

  // advance the led model by one item and queue the status it should report
  task automatic predict_status(input lbps_in_t it);
    lbps_out_t r;
    r.error = 1'b0;
    case (it.operation)
      OP_TICK: begin
        if (timer_run && ticks_rem > 16'd1) begin
          ticks_rem = ticks_rem - 16'd1;
        end else if (timer_run) begin
          ticks_rem = '0;
          if (!led_lit) begin
            led_lit   = 1'b1;
            ticks_rem = cur_on_t;
          end else begin
            led_lit = 1'b0;
            if (pulses_rem != 0) pulses_rem = pulses_rem - 8'd1;
            if (pulses_rem != 0 && cur_off_t != 0) begin
              ticks_rem = cur_off_t;
            end else if (led_mode == MODE_ONCE) begin
              cur_on_t    = keep_on_t;
              cur_off_t   = keep_off_t;
              cur_burst_n = keep_burst_n;
              cur_gap_t   = keep_gap_t;
              n_restores++;
              enter_mode(keep_mode);
            end else if (led_mode == MODE_CONT) begin
              pulses_rem = cur_burst_n;
              ticks_rem  = cur_gap_t;
            end else begin
              timer_run = 1'b0;
            end
          end
        end
      end
      OP_SOLID: enter_mode(it.level ? MODE_ON : MODE_OFF);
      OP_BLINK: begin
        if (it.on_time == 0 || (it.off_time == 0 && it.burst_length != 0)) begin
          r.error = 1'b1;
          n_rejected++;
        end else begin
          // one-shot pattern remembers what to go back to
          if (it.repeat_gap == 0) begin
            keep_mode    = led_mode;
            keep_on_t    = cur_on_t;
            keep_off_t   = cur_off_t;
            keep_burst_n = cur_burst_n;
            keep_gap_t   = cur_gap_t;
          end
          cur_on_t    = it.on_time;
          cur_off_t   = it.off_time;
          cur_burst_n = it.burst_length;
          cur_gap_t   = it.repeat_gap;
          enter_mode(it.repeat_gap != 0 ? MODE_CONT : MODE_ONCE);
        end
      end
      default: ;
    endcase
    r.led      = led_lit;
    r.mode_now = led_mode;
    exp_status_q.push_back(r);
  endtask

  function automatic lbps_in_t cmd(input logic [1:0] op, input logic lvl,
                                   input logic [15:0] on_t, input logic [15:0] off_t,
                                   input logic [7:0] burst, input logic [15:0] gap);
    lbps_in_t it;
    it.operation    = op;
    it.level        = lvl;
    it.on_time      = on_t;
    it.off_time     = off_t;
    it.burst_length = burst;
    it.repeat_gap   = gap;
    return it;
  endfunction

  function automatic lbps_in_t random_command();
    lbps_in_t    it;
    logic [63:0] raw;
    int          pick;
    raw  = {$urandom, $urandom};
    it   = raw[$bits(lbps_in_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 64) begin
      it.operation = OP_TICK;
    end else if (pick < 71) begin
      it.operation = OP_SOLID;
    end else if (pick < 97) begin
      it.operation = OP_BLINK;
      if ($urandom_range(9) < 8) begin
        // short timings so bursts and restores actually complete
        it.on_time      = 16'($urandom_range(1, 4));
        it.off_time     = 16'($urandom_range(1, 3));
        it.burst_length = 8'($urandom_range(0, 4));
        it.repeat_gap   = $urandom_range(1) ? 16'd0 : 16'($urandom_range(1, 5));
      end else begin
        case ($urandom_range(3))
          0: it.on_time = '0;
          1: begin
            it.off_time     = '0;
            it.burst_length = it.burst_length | 8'd1;
          end
          2: begin
            it.off_time     = '0;
            it.burst_length = '0;
          end
          default: ;
        endcase
      end
    end else begin
      it.operation = OP_UNUSED;
    end
    return it;
  endfunction

  // called and returns at a falling edge; leaves in_valid high
  task automatic send_item(input lbps_in_t it);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_status(it);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (exp_status_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic test_directed();
    send_item(cmd(OP_TICK, 1'b0, 16'h0000, 16'h0000, 8'h00, 16'h0000));
    send_item(cmd(OP_UNUSED, 1'b1, 16'hffff, 16'hffff, 8'hff, 16'hffff));
    send_item(cmd(OP_SOLID, 1'b1, 16'h0000, 16'h0000, 8'h00, 16'h0000));
    send_item(cmd(OP_TICK, 1'b1, 16'hffff, 16'hffff, 8'hff, 16'hffff));
    send_item(cmd(OP_SOLID, 1'b0, 16'hffff, 16'hffff, 8'hff, 16'hffff));
    // invalid blinks: zero on time, zero off time inside a burst; then a valid one
    send_item(cmd(OP_BLINK, 1'b0, 16'h0000, 16'h0005, 8'h02, 16'h0000));
    send_item(cmd(OP_BLINK, 1'b1, 16'h0003, 16'h0000, 8'h03, 16'h0004));
    send_item(cmd(OP_BLINK, 1'b0, 16'hffff, 16'hffff, 8'hff, 16'hffff));
    send_item(cmd(OP_TICK, 1'b0, 16'h0000, 16'h0000, 8'h00, 16'h0000));
    // one-shot over a continuous pattern, zero off time with zero burst is legal
    send_item(cmd(OP_BLINK, 1'b0, 16'h0001, 16'h0000, 8'h00, 16'h0000));
    send_item(cmd(OP_TICK, 1'b0, 16'h0000, 16'h0000, 8'h00, 16'h0000));
    send_item(cmd(OP_TICK, 1'b0, 16'h0000, 16'h0000, 8'h00, 16'h0000));
    send_item(cmd(OP_SOLID, 1'b1, 16'h0000, 16'h0000, 8'h00, 16'h0000));
    send_item(cmd(OP_BLINK, 1'b0, 16'h0002, 16'h0001, 8'h02, 16'h0000));
    // one-shot over a one-shot: the restore replays the first pattern
    send_item(cmd(OP_BLINK, 1'b1, 16'h0001, 16'h0001, 8'h01, 16'h0000));
    repeat (6) send_item(cmd(OP_TICK, 1'b0, 16'h0000, 16'h0000, 8'h00, 16'h0000));
    send_item(cmd(OP_BLINK, 1'b0, 16'h0001, 16'h0001, 8'h01, 16'h0001));
    repeat (3) send_item(cmd(OP_TICK, 1'b1, 16'h0000, 16'h0000, 8'h00, 16'h0000));
    wait_drain();
  endtask

  // output held off while the input keeps offering, so the block backs up
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_len      = 80;
    send_item(cmd(OP_BLINK, 1'b0, 16'h0002, 16'h0001, 8'h03, 16'h0002));
    repeat (29) send_item(random_command());
    wait_drain();
  endtask

  task automatic test_random_traffic(input int n, input int snd_pct, input int rcv_pct);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    repeat (n) send_item(random_command());
    wait_drain();
  endtask

  // result side: ready pattern, with a counted hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len != 0) begin
        out_ready <= 1'b0;
        for (int i = 0; i < hold_len; i++) @(negedge clk);
        hold_len = 0;
      end
      out_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (exp_status_q.size() == 0) begin
        $display("%0t: unexpected item led=%0b error=%0b mode=%0d", $time,
                 out_data.led, out_data.error, out_data.mode_now);
        n_fail++;
      end else begin
        want_status = exp_status_q.pop_front();
        n_checked++;
        if (out_data.led !== want_status.led || out_data.error !== want_status.error ||
            out_data.mode_now !== want_status.mode_now) begin
          $display("%0t: mismatch expected led=%0b error=%0b mode=%0d, got led=%0b error=%0b mode=%0d",
                   $time, want_status.led, want_status.error, want_status.mode_now,
                   out_data.led, out_data.error, out_data.mode_now);
          n_fail++;
        end
      end
    end
  end

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    hold_len = 0;
    n_sent = 0; n_checked = 0; n_rejected = 0; n_restores = 0; n_fail = 0;
    led_mode = MODE_OFF; led_lit = 1'b0; timer_run = 1'b0;
    ticks_rem = '0; pulses_rem = '0;
    cur_on_t = '0; cur_off_t = '0; cur_burst_n = '0; cur_gap_t = '0;
    keep_mode = MODE_OFF; keep_on_t = '0; keep_off_t = '0; keep_burst_n = '0; keep_gap_t = '0;
    send_idle_pct = 38;
    recv_idle_pct = 65;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_random_traffic(600, 38, 65);
    test_backpressure();
    test_random_traffic(600, 65, 38);
    test_random_traffic(600, 0, 0);

    $display("sent %0d items, checked %0d results: %0d rejected blinks, %0d one-shot restores",
             n_sent, n_checked, n_rejected, n_restores);
    $display("traffic ran with both idle mixes, no idling, and a long result hold-off");
    if (n_fail == 0 && exp_status_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
